// ----- rtl/qsm_pkg.sv -----
// qsm_pkg: shared types, constants and the phase table of the QAM symbol mapper.
// No dependencies; used by every rtl file of the block but qsm_checker.
package qsm_pkg;

  localparam int MAX_BITS        = 10;
  localparam int PHASE_FRAC_BITS = 14;
  localparam int ANG_BITS        = 24;
  localparam int CORDIC_STEPS    = 24;
  localparam int PRESHIFT        = 30;
  localparam int CODE_W          = 10;
  localparam int BPS_W           = 4;
  localparam int PN_W            = 15;
  localparam int EN_W            = 20;
  localparam int COORD_W         = 6;
  localparam int ENERGY_W        = 11;
  localparam int PHASE_W         = 15;
  localparam int BAND_W          = 16;
  localparam int EBAND_W         = 21;
  localparam int TAB_DEPTH       = 256;
  localparam int FIFO_DEPTH      = 2;

  // register indexes
  localparam logic [1:0] REG_BPS          = 2'd0;
  localparam logic [1:0] REG_PHASE_NOISE  = 2'd1;
  localparam logic [1:0] REG_ENERGY_NOISE = 2'd2;

  typedef logic [ANG_BITS-1:0] ang_tab_t [TAB_DEPTH];

  // mapped point handed from front to back
  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] ci;
    logic signed [COORD_W-1:0] cq;
  } pt_t;

  typedef struct packed {
    logic                       code_valid;
    logic signed [COORD_W-1:0]  in_phase;
    logic signed [COORD_W-1:0]  quadrature;
    logic [ENERGY_W-1:0]        energy;
    logic [PHASE_W-1:0]         phase;
    logic signed [BAND_W-1:0]   phase_low;
    logic [BAND_W-1:0]          phase_high;
    logic signed [EBAND_W-1:0]  energy_low;
    logic [EBAND_W-1:0]         energy_high;
  } res_t;

  localparam longint ATAN_PI [CORDIC_STEPS] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  // first-quadrant angle atan(ay/ax)/pi, vectoring CORDIC, 24 fraction bits
  function automatic longint fq_angle(longint ax, longint ay);
    longint x, y, z, dx, dy;
    x = ax <<< PRESHIFT;
    y = ay <<< PRESHIFT;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_PI[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_PI[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) <<< (ANG_BITS - 1))) z = longint'(1) <<< (ANG_BITS - 1);
    return z;
  endfunction

  // index {|I|>>1, |Q|>>1}, both magnitudes odd 1..31
  function automatic ang_tab_t build_tab();
    ang_tab_t t;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      t[k] = ANG_BITS'(fq_angle(longint'(2 * (k / 16) + 1), longint'(2 * (k % 16) + 1)));
    end
    return t;
  endfunction

  localparam ang_tab_t ANG_TAB = build_tab();

endpackage

// ----- rtl/qsm_front.sv -----
// qsm_front: clamps the order, checks the code and finds the grid point.
// Depends on qsm_pkg.
module qsm_front (
  input  logic [qsm_pkg::BPS_W-1:0]  bps,
  input  logic [qsm_pkg::CODE_W-1:0] code,
  output qsm_pkg::pt_t               pt
);

  logic [qsm_pkg::BPS_W-1:0]  b;
  logic [2:0]                 k;      // log2 of the power-of-two part of the side
  logic                       div3;   // side carries a factor of three
  logic [5:0]                 side;
  logic [qsm_pkg::CODE_W-1:0] v;
  logic [15:0]                prod;
  logic [5:0]                 row;
  logic [11:0]                rs;
  logic [5:0]                 col;
  logic signed [7:0]          ci_w, cq_w;

  always_comb begin
    if (bps == '0) b = 4'd1;
    else if (bps > 4'(qsm_pkg::MAX_BITS)) b = 4'(qsm_pkg::MAX_BITS);
    else b = bps;
    k = 3'd1; div3 = 1'b0; side = 6'd2;
    unique case (b)
      4'd3, 4'd4: begin k = 3'd2; side = 6'd4; end
      4'd5:       begin k = 3'd1; div3 = 1'b1; side = 6'd6; end
      4'd6:       begin k = 3'd3; side = 6'd8; end
      4'd7:       begin k = 3'd2; div3 = 1'b1; side = 6'd12; end
      4'd8:       begin k = 3'd4; side = 6'd16; end
      4'd9:       begin k = 3'd3; div3 = 1'b1; side = 6'd24; end
      4'd10:      begin k = 3'd5; side = 6'd32; end
      default:    begin k = 3'd1; side = 6'd2; end
    endcase
    v    = code >> k;
    prod = 16'(v[7:0]) * 16'd171;   // exact v/3 for v below 256
    row  = div3 ? 6'(prod >> 9) : 6'(v);
    rs   = 12'(row) * 12'(side);
    col  = 6'(12'(code) - rs);
    ci_w = 8'(side) - 8'sd1 - 8'(row) * 8'sd2;
    cq_w = 8'(side) - 8'sd1 - 8'(col) * 8'sd2;
    pt.ok = ((code >> b) == '0);
    pt.ci = ci_w[5:0];
    pt.cq = cq_w[5:0];
  end

endmodule

// ----- rtl/qsm_fifo.sv -----
// qsm_fifo: two-entry queue of mapped points between front and back.
// Depends on qsm_pkg.
module qsm_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  qsm_pkg::pt_t wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic         rd_valid,
  output qsm_pkg::pt_t rd_data
);

  qsm_pkg::pt_t mem [qsm_pkg::FIFO_DEPTH];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  assign full     = (count == 2'(qsm_pkg::FIFO_DEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

endmodule

// ----- rtl/qsm_back.sv -----
// qsm_back: two-stage pipe, angle table and energy, then phase and noise bands.
// Depends on qsm_pkg.
module qsm_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  qsm_pkg::pt_t             in_pt,
  input  logic [qsm_pkg::PN_W-1:0] phase_jitter,
  input  logic [qsm_pkg::EN_W-1:0] energy_noise,
  output logic                     out_valid,
  input  logic                     out_ready,
  output qsm_pkg::res_t            out_res
);

  logic                              a_valid, a_ready, b_ready;
  qsm_pkg::pt_t                      a_pt;
  logic [qsm_pkg::ANG_BITS-1:0]      a_ang;
  logic [qsm_pkg::ENERGY_W-1:0]      a_energy;
  logic [4:0]                        ai, aq;
  logic [25:0]                       t;
  logic [25:0]                       p;
  logic [qsm_pkg::PHASE_W-1:0]       ph;
  logic [18:0]                       e256;
  qsm_pkg::res_t                     res_next;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    ai = in_pt.ci[5] ? 5'(-in_pt.ci) : in_pt.ci[4:0];
    aq = in_pt.cq[5] ? 5'(-in_pt.cq) : in_pt.cq[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (a_ready) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_pt     <= in_pt;
      a_ang    <= qsm_pkg::ANG_TAB[{ai[4:1], aq[4:1]}];
      a_energy <= 11'(10'(ai) * 10'(ai)) + 11'(10'(aq) * 10'(aq));
    end
  end

  always_comb begin
    priority if (!a_pt.ci[5] && !a_pt.cq[5]) t = 26'(a_ang);
    else if (a_pt.ci[5] && !a_pt.cq[5]) t = (26'd1 << qsm_pkg::ANG_BITS) - 26'(a_ang);
    else if (a_pt.ci[5]) t = (26'd1 << qsm_pkg::ANG_BITS) + 26'(a_ang);
    else t = (26'd2 << qsm_pkg::ANG_BITS) - 26'(a_ang);
    p    = (t + 26'd512) >> (qsm_pkg::ANG_BITS - qsm_pkg::PHASE_FRAC_BITS);
    ph   = p[qsm_pkg::PHASE_W-1:0];   // wraps 2 to 0
    e256 = {a_energy, 8'd0};
    res_next.code_valid  = 1'b1;
    res_next.in_phase    = a_pt.ci;
    res_next.quadrature  = a_pt.cq;
    res_next.energy      = a_energy;
    res_next.phase       = ph;
    res_next.phase_low   = 16'(ph) - 16'(phase_jitter);
    res_next.phase_high  = 16'(ph) + 16'(phase_jitter);
    res_next.energy_low  = 21'(e256) - 21'(energy_noise);
    res_next.energy_high = 21'(e256) + 21'(energy_noise);
    if (!a_pt.ok) res_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (b_ready) out_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) out_res <= res_next;
  end

endmodule

// ----- rtl/qam_symbol_mapper.sv -----
// qam_symbol_mapper: M-QAM mapper, code in, point, energy, phase and bands out.
// Depends on qsm_pkg, qsm_front, qsm_fifo, qsm_back.
// Throughput: one beat per cycle while m_tready stays high. An accepted beat is written
// into the queue, then passes the table/energy stage, then the output register that
// drives m_tvalid. The angle comes from a 256-entry constant table.
// Reset (rst, synchronous): registers to 4 / 0 / 0, queue and pipe emptied.
module qam_symbol_mapper (
  input  logic          clk,
  input  logic          rst,
  // input stream: tdata[9:0] symbol_code, upper bits zero
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,
  // output stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // tdata: [5:0] in_phase, [11:6] quadrature, [22:12] energy, [37:23] phase,
  // [53:38] phase_low, [69:54] phase_high, [90:70] energy_low, [111:91] energy_high
  output logic [111:0]  m_tdata,
  // tuser: [0] code_valid
  output logic          m_tuser,
  // register write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [19:0]   cfg_data
);

  logic [qsm_pkg::BPS_W-1:0] bps;
  logic [qsm_pkg::PN_W-1:0]  phase_jitter;
  logic [qsm_pkg::EN_W-1:0]  energy_noise;

  qsm_pkg::pt_t  front_pt, q_pt;
  qsm_pkg::res_t res;
  logic          q_full, q_valid, back_ready;

  // register file; always ready, unused index ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bps          <= 4'd4;
      phase_jitter <= '0;
      energy_noise <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qsm_pkg::REG_BPS:          bps          <= cfg_data[qsm_pkg::BPS_W-1:0];
        qsm_pkg::REG_PHASE_NOISE:  phase_jitter <= cfg_data[qsm_pkg::PN_W-1:0];
        qsm_pkg::REG_ENERGY_NOISE: energy_noise <= cfg_data[qsm_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: map the code combinationally straight into the queue
  qsm_front u_front (
    .bps  (bps),
    .code (s_tdata[qsm_pkg::CODE_W-1:0]),
    .pt   (front_pt)
  );

  // ready depends only on queue occupancy, never on the output side
  assign s_tready = !q_full;

  qsm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (s_tvalid && s_tready),
    .wr_data  (front_pt),
    .full     (q_full),
    .rd_en    (q_valid && back_ready),
    .rd_valid (q_valid),
    .rd_data  (q_pt)
  );

  // back: angle lookup, energy, phase rounding and noise bands
  qsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (back_ready),
    .in_pt        (q_pt),
    .phase_jitter (phase_jitter),
    .energy_noise (energy_noise),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_res      (res)
  );

  assign m_tuser = res.code_valid;
  assign m_tdata = {res.energy_high, res.energy_low, res.phase_high, res.phase_low,
                    res.phase, res.energy, res.quadrature, res.in_phase};

endmodule

// ----- rtl/qsm_checker.sv -----
// qsm_checker: port-level assertions for qam_symbol_mapper, bound to the top.
// Depends on qam_symbol_mapper ports only.
module qsm_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic         m_tuser
);

  logic [20:0] esum;
  assign esum = m_tdata[90:70] + m_tdata[111:91];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat dropped under stall");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid code with nonzero fields");

  a_odd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[0] && m_tdata[6])
    else $error("coordinate not odd");

  a_band: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> esum == {1'b0, m_tdata[22:12], 9'd0})
    else $error("energy band not centered on energy");

endmodule

bind qam_symbol_mapper qsm_checker u_qsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- test/qam_symbol_mapper_tb.sv -----
// qam_symbol_mapper_tb: self-checking bench for the QAM symbol mapper.
// Depends on qsm_pkg and qam_symbol_mapper; predicts each point, energy, phase and band.
`timescale 1ns / 1ps
module qam_symbol_mapper_tb;

  typedef logic [qsm_pkg::CODE_W-1:0] code_t;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [15:0]   s_tdata;   // [9:0] symbol_code
  logic          m_tvalid;
  logic          m_tready;
  logic [111:0]  m_tdata;   // in_phase, quadrature, energy, phase, bands (low bits up)
  logic          m_tuser;   // [0] code_valid
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [19:0]   cfg_data;

  qam_symbol_mapper u_top (.*);

  // arctangent of 2^-i over pi, 24 fraction bits
  localparam longint ATAN_STEP [24] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1
  };

  // mapper settings as the bench believes them
  logic [qsm_pkg::BPS_W-1:0] bps_cfg;
  logic [qsm_pkg::PN_W-1:0]  pn_cfg;
  logic [qsm_pkg::EN_W-1:0]  en_cfg;

  qsm_pkg::res_t expected_points[$];
  int   fail_count;
  bit   hold_off;      // requests a long receiver stall
  bit   stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
    fail_count++;
  endtask

  // atan(ay/ax)/pi by vectoring CORDIC; >>> on longint floors as the spec asks
  function automatic longint quadrant_angle(longint ax, longint ay);
    longint x, y, z, dx, dy;
    x = ax <<< 30;
    y = ay <<< 30;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) <<< 23)) z = longint'(1) <<< 23;
    return z;
  endfunction

  function automatic qsm_pkg::res_t map_symbol(input code_t code);
    qsm_pkg::res_t r;
    int     b, m, side, ci, cq, en;
    longint a, t, p, e256;
    r = '0;
    b = bps_cfg;
    if (b < 1) b = 1;
    if (b > qsm_pkg::MAX_BITS) b = qsm_pkg::MAX_BITS;
    m = 1 << b;
    if (code >= m) return r;
    if (b % 2 == 0) side = 1 << (b / 2);
    else begin
      side = ((1 << ((b + 1) / 2)) + (1 << ((b - 1) / 2))) / 2;
      if (side % 2) side++;
    end
    ci = (side - 1) - 2 * (code / side);
    cq = (side - 1) - 2 * (code % side);
    en = ci * ci + cq * cq;
    a = quadrant_angle(ci < 0 ? -ci : ci, cq < 0 ? -cq : cq);
    if (ci > 0 && cq > 0) t = a;
    else if (ci < 0 && cq > 0) t = (longint'(1) <<< 24) - a;
    else if (ci < 0) t = (longint'(1) <<< 24) + a;
    else t = (longint'(2) <<< 24) - a;
    p = (t + 512) >>> 10;
    if (p >= 32768) p -= 32768;   // angle of 2 wraps to 0
    e256 = longint'(en) * 256;
    r.code_valid  = 1'b1;
    r.in_phase    = ci[5:0];
    r.quadrature  = cq[5:0];
    r.energy      = en[10:0];
    r.phase       = p[14:0];
    r.phase_low   = 16'(p - pn_cfg);
    r.phase_high  = 16'(p + pn_cfg);
    r.energy_low  = 21'(e256 - en_cfg);
    r.energy_high = 21'(e256 + en_cfg);
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      qsm_pkg::REG_BPS:          bps_cfg = val[qsm_pkg::BPS_W-1:0];
      qsm_pkg::REG_PHASE_NOISE:  pn_cfg  = val[qsm_pkg::PN_W-1:0];
      qsm_pkg::REG_ENERGY_NOISE: en_cfg  = val[qsm_pkg::EN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // one symbol beat; expectation queued at acceptance
  task automatic send_symbol(input code_t code);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, code};
    do @(posedge clk); while (!s_tready);
    expected_points.push_back(map_symbol(code));
    @(negedge clk);
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (expected_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // burst sender: random burst lengths and gaps
  task automatic send_burst(input int n, input int bps);
    int left, gap;
    left = 0;
    for (int k = 0; k < n; k++) begin
      if (left == 0) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          go_idle();
          repeat (gap) @(negedge clk);
        end
        left = $urandom_range(1, 20);
      end
      left--;
      // mostly in-range codes, some beyond M
      if ($urandom_range(0, 7) == 0) send_symbol(code_t'($urandom));
      else send_symbol(code_t'($urandom_range(0, (1 << bps) - 1)));
    end
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int pat;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      pat = $urandom_range(0, 15);
      m_tready <= (pat < 10) || stim_done;
    end
  end

  // result checker
  always @(posedge clk) begin
    qsm_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = expected_points.pop_front();
        if (m_tuser !== want.code_valid) report("code_valid", m_tuser, want.code_valid);
        if (m_tdata[5:0] !== want.in_phase)
          report("in_phase", $signed(m_tdata[5:0]), want.in_phase);
        if (m_tdata[11:6] !== want.quadrature)
          report("quadrature", $signed(m_tdata[11:6]), want.quadrature);
        if (m_tdata[22:12] !== want.energy) report("energy", m_tdata[22:12], want.energy);
        if (m_tdata[37:23] !== want.phase) report("phase", m_tdata[37:23], want.phase);
        if (m_tdata[53:38] !== want.phase_low)
          report("phase_low", m_tdata[53:38], want.phase_low);
        if (m_tdata[69:54] !== want.phase_high)
          report("phase_high", m_tdata[69:54], want.phase_high);
        if (m_tdata[90:70] !== want.energy_low)
          report("energy_low", m_tdata[90:70], want.energy_low);
        if (m_tdata[111:91] !== want.energy_high)
          report("energy_high", m_tdata[111:91], want.energy_high);
      end
    end
  end

  // reset-default grid, corner codes and codes past M
  task automatic test_defaults();
    int codes [9] = '{0, 3, 5, 10, 12, 15, 16, 1023, 512};
    foreach (codes[i])
      send_symbol(code_t'(codes[i]));
    drain();
  endtask

  // every order but 4, including out-of-range settings, with extreme bands
  task automatic test_orders();
    int bl [12] = '{0, 1, 2, 3, 5, 7, 9, 10, 11, 15, 6, 8};
    write_reg(qsm_pkg::REG_PHASE_NOISE, 20'd16384);
    write_reg(qsm_pkg::REG_ENERGY_NOISE, 20'hFFFFF);
    foreach (bl[i]) begin
      write_reg(qsm_pkg::REG_BPS, 20'(bl[i]));
      send_symbol(10'd0);
      send_symbol(10'd1023);
      send_symbol(code_t'($urandom));
      drain();
    end
    write_reg(2'd3, 20'h5A5A5);   // unused index, ignored
  endtask

  // long receiver hold-off while the sender keeps pushing
  task automatic test_backpressure();
    write_reg(qsm_pkg::REG_BPS, 20'd6);
    write_reg(qsm_pkg::REG_PHASE_NOISE, 20'h7FFF);
    hold_off = 1'b1;
    send_burst(40, 6);
    drain();
  endtask

  task automatic test_random();
    int bps;
    for (int ph = 0; ph < 8; ph++) begin
      bps = $urandom_range(1, 10);
      write_reg(qsm_pkg::REG_BPS, 20'(bps));
      write_reg(qsm_pkg::REG_PHASE_NOISE, 20'($urandom_range(0, 32767)));
      write_reg(qsm_pkg::REG_ENERGY_NOISE, 20'($urandom));
      send_burst(100, bps);
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    fail_count = 0;
    bps_cfg = 4'd4;
    pn_cfg = '0;
    en_cfg = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_orders();
    test_backpressure();
    test_random();
    stim_done = 1'b1;
    drain();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- qam_symbol_mapper.f -----
rtl/qsm_pkg.sv
rtl/qsm_front.sv
rtl/qsm_fifo.sv
rtl/qsm_back.sv
rtl/qam_symbol_mapper.sv
rtl/qsm_checker.sv
test/qam_symbol_mapper_tb.sv
